>>> rtl/pss_pkg.sv
// Shared types and constants for the positional sequence store.
// Used by pss_cell and positional_sequence_store_unit; depends on nothing.
package pss_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 8;
  // Wide enough for any length up to the largest supported capacity (256).
  localparam int unsigned CmpW  = 9;

  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_END   = 3'd1,
    KIND_INS_AT    = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_END   = 3'd4,
    KIND_DEL_AT    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Command broadcast to every cell of the row in the cycle a request commits.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [PosW-1:0]  idx;
    logic [DataW-1:0] value;
  } cell_cmd_t;

endpackage

>>> rtl/pss_cell.sv
// One storage cell of the sequence row: holds a single entry and shifts
// toward or away from its neighbors on a committed insert or delete.
// Depends on pss_pkg.
module pss_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                      clk_i,
  input  pss_pkg::cell_cmd_t        cmd_i,
  input  logic [pss_pkg::DataW-1:0] left_i,
  input  logic [pss_pkg::DataW-1:0] right_i,
  output logic [pss_pkg::DataW-1:0] value_o
);
  import pss_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(Index);

  logic [DataW-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (MyIdx == cmd_i.idx) begin
        entry_d = cmd_i.value;
      end else if (MyIdx > cmd_i.idx) begin
        entry_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (MyIdx >= cmd_i.idx) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign value_o = entry_q;

endmodule

>>> rtl/positional_sequence_store_unit.sv
// Top level of the positional sequence store: request decode, length
// tracking, result registers and the row of pss_cell storage cells.
// Depends on pss_pkg and pss_cell.
//
// The unit keeps an ordered list of up to CAPACITY signed 32-bit entries. A
// request is taken at any clock edge where start_i is high; busy_o never
// rises, so a new request may follow in every cycle. Each request commits in
// the cycle it is taken: every cell of the storage row loads its own entry,
// the new value or a neighbor's entry in that same cycle, whatever the index
// of the insert or delete. The result appears on the next cycle
// for exactly one cycle with done_o high and cannot be held off by the
// receiver. Results come back in request order, one per request.
module positional_sequence_store_unit #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned LenW = $clog2(CAPACITY + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [2:0]                kind_i,
  input  logic signed [31:0]        value_i,
  input  logic [7:0]                position_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [LenW-1:0]           length_now_o,
  output logic signed [31:0]        removed_value_o,
  output logic signed [31:0]        front_value_o
);
  import pss_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam logic [CmpW-1:0] CapC = CmpW'(CAPACITY);

  logic [DataW-1:0] cell_val [CAPACITY];
  cell_cmd_t        cmd;

  logic [LenW-1:0]  len_q, len_d;
  logic             done_q;
  status_e          status_q, status_d;
  logic [LenW-1:0]  len_out_q;
  logic [DataW-1:0] removed_q, removed_d;
  logic [DataW-1:0] front_q, front_d;

  logic [CmpW-1:0]  len_ext;
  logic [CmpW-1:0]  idx;
  logic             accept;

  assign accept  = start_i && !busy_o;
  assign len_ext = CmpW'(len_q);

  always_comb begin
    status_d  = ST_DONE;
    removed_d = '0;
    len_d     = len_q;
    idx       = '0;
    cmd.ins   = 1'b0;
    cmd.del   = 1'b0;
    cmd.value = value_i;
    case (kind_e'(kind_i))
      KIND_INS_FRONT, KIND_INS_END, KIND_INS_AT: begin
        case (kind_e'(kind_i))
          KIND_INS_FRONT: idx = '0;
          KIND_INS_END:   idx = len_ext;
          default:        idx = CmpW'(position_i);
        endcase
        if (idx > len_ext) begin
          status_d = ST_RANGE;
        end else if (len_ext >= CapC) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = accept;
          len_d   = len_q + LenW'(1);
        end
      end
      KIND_DEL_FRONT, KIND_DEL_END, KIND_DEL_AT: begin
        case (kind_e'(kind_i))
          KIND_DEL_FRONT: idx = '0;
          KIND_DEL_END:   idx = len_ext - CmpW'(1);
          default:        idx = CmpW'(position_i);
        endcase
        if (len_q == '0) begin
          status_d = ST_EMPTY;
        end else if (idx >= len_ext) begin
          status_d = ST_RANGE;
        end else begin
          cmd.del   = accept;
          removed_d = cell_val[idx[AddrW-1:0]];
          len_d     = len_q - LenW'(1);
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
    // A committed index is always below CAPACITY, so it fits the position width.
    cmd.idx = idx[PosW-1:0];
  end

  // Entry at index zero once the request has taken effect.
  always_comb begin
    front_d = cell_val[0];
    if (cmd.ins && cmd.idx == '0) begin
      front_d = value_i;
    end else if (cmd.del && cmd.idx == '0) begin
      front_d = cell_val[1];
    end
    if (len_d == '0) begin
      front_d = '0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    pss_cell #(
      .Index(i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left_v),
      .right_i(right_v),
      .value_o(cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        len_q <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      len_out_q <= len_d;
      removed_q <= removed_d;
      front_q   <= front_d;
    end
  end

  assign busy_o          = 1'b0;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign length_now_o    = len_out_q;
  assign removed_value_o = removed_q;
  assign front_value_o   = front_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(CAPACITY))
    else $error("stored length exceeds capacity");

  a_done_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i))
    else $error("result strobe without a request one cycle earlier");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> length_now_o == LenW'(CAPACITY))
    else $error("full status reported below capacity");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (length_now_o == '0 && front_value_o == '0))
    else $error("empty status with stored entries");

  a_len_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> length_now_o == len_q)
    else $error("reported length differs from stored length");

endmodule

>>> sim/positional_sequence_store_unit_tb.sv
// Self-checking testbench for positional_sequence_store_unit: directed and random
// inserts and deletes, checked against a shadow copy of the stored sequence.
// Depends on pss_pkg and the positional_sequence_store_unit RTL.
module positional_sequence_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned LenW        = $clog2(CAPACITY + 1);
  localparam int unsigned RandomItems = 720;
  localparam int unsigned TailItems   = 60;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReports  = 100;

  // Request codes that the block must ignore.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         position;
  } request_t;

  typedef struct packed {
    status_e            status;
    logic [LenW-1:0]    length_now;
    logic signed [31:0] removed;
    logic signed [31:0] front;
  } answer_t;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     start_i    = 1'b0;
  logic [2:0]               kind_i     = '0;
  logic signed [31:0]       value_i    = '0;
  logic [7:0]               position_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [1:0]               status_o;
  logic [LenW-1:0]          length_now_o;
  logic signed [31:0]       removed_value_o;
  logic signed [31:0]       front_value_o;

  request_t           queued_requests[$];
  answer_t            awaited_answers[$];
  logic signed [31:0] shadow_entries[CAPACITY];
  int unsigned        shadow_len = 0;

  logic        req_taken   = 1'b0;
  int unsigned gap_left    = 0;
  int unsigned idle_pct    = 0;
  int unsigned sent_count  = 0;
  int unsigned taken_count = 0;
  int unsigned checked     = 0;
  int unsigned error_count = 0;
  int unsigned peak_len    = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen[4];

  positional_sequence_store_unit #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .length_now_o   (length_now_o),
    .removed_value_o(removed_value_o),
    .front_value_o  (front_value_o)
  );

  always #4 clk_i = ~clk_i;

  // Applies one request to the shadow sequence and returns what the block must answer.
  function automatic answer_t predict_answer(request_t r);
    answer_t     a;
    int unsigned idx;
    int unsigned i;
    a.status  = ST_DONE;
    a.removed = '0;
    case (r.kind)
      KIND_INS_FRONT, KIND_INS_END, KIND_INS_AT: begin
        if (r.kind == KIND_INS_FRONT) idx = 0;
        else if (r.kind == KIND_INS_END) idx = shadow_len;
        else idx = 32'(r.position);
        // The index check takes priority over the full check.
        if (idx > shadow_len) begin
          a.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          a.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > idx; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[idx] = r.value;
          shadow_len++;
        end
      end
      KIND_DEL_FRONT, KIND_DEL_END, KIND_DEL_AT: begin
        if (shadow_len == 0) begin
          a.status = ST_EMPTY;
        end else begin
          if (r.kind == KIND_DEL_FRONT) idx = 0;
          else if (r.kind == KIND_DEL_END) idx = shadow_len - 1;
          else idx = 32'(r.position);
          if (idx >= shadow_len) begin
            a.status = ST_RANGE;
          end else begin
            a.removed = shadow_entries[idx];
            for (i = idx; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i + 1];
            shadow_len--;
          end
        end
      end
      default: ;
    endcase
    a.length_now = LenW'(shadow_len);
    a.front      = (shadow_len > 0) ? shadow_entries[0] : '0;
    return a;
  endfunction

  task automatic add_request(logic [2:0] kind, logic signed [31:0] value, logic [7:0] pos);
    queued_requests.push_back('{kind: kind, value: value, position: pos});
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: a request stays on the ports until it is taken, then the next one
  // follows or an idle burst starts.
  always @(negedge clk_i) begin : drive_requests
    request_t nxt;
    logic     send;
    nxt  = '{kind: 3'($urandom), value: $urandom, position: 8'($urandom)};
    send = 1'b0;
    if (rst_ni && (!start_i || req_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (queued_requests.size() != 0) begin
        if (queued_requests.size() < TailItems || $urandom_range(0, 99) >= idle_pct) begin
          nxt  = queued_requests.pop_front();
          send = 1'b1;
          sent_count++;
          if (sent_count % 40 == 0) begin
            case ($urandom_range(0, 2))
              0: idle_pct <= 0;
              1: idle_pct <= 12;
              default: idle_pct <= 40;
            endcase
          end
        end else begin
          gap_left <= $urandom_range(0, 12);
        end
      end
      start_i    <= send;
      kind_i     <= nxt.kind;
      value_i    <= nxt.value;
      position_i <= nxt.position;
    end else if (!rst_ni) begin
      start_i <= 1'b0;
    end
  end

  // Monitor: records taken requests and checks every result against the oldest
  // outstanding expectation.
  always @(posedge clk_i) begin : check_results
    answer_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        want = predict_answer('{kind: kind_i, value: value_i, position: position_i});
        awaited_answers.push_back(want);
        taken_count++;
        status_seen[want.status]++;
        if (shadow_len > peak_len) peak_len = shadow_len;
      end
      if (done_o) begin
        if (awaited_answers.size() == 0) begin
          error_count++;
          $display("%0t ns: result with no request outstanding, expected none, actual status %0d",
                   $time, status_o);
        end else begin
          want = awaited_answers.pop_front();
          checked++;
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("length_now", 32'(want.length_now), 32'(length_now_o));
          check_field("removed_value", want.removed, removed_value_o);
          check_field("front_value", want.front, front_value_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned mode;
    int unsigned ins_pct;
    int unsigned pick;
    logic [2:0]  kind;
    logic [7:0]  pos;

    // Deletes on an empty sequence report empty before any index check.
    add_request(KIND_DEL_AT, 32'sd5, 8'd255);
    add_request(KIND_DEL_END, 32'sd0, 8'd0);
    add_request(KIND_INS_AT, 32'sd9, 8'd1);
    add_request(KIND_INS_FRONT, 32'sh7FFF_FFFF, 8'd0);
    add_request(KIND_INS_END, 32'sh8000_0000, 8'd0);
    // An insert at an index equal to the length appends.
    add_request(KIND_INS_AT, -32'sd1, 8'd2);
    add_request(KIND_INS_AT, 32'sd0, 8'd1);
    for (n = 0; n < 12; n++) begin
      case (n % 3)
        0: kind = KIND_INS_FRONT;
        1: kind = KIND_INS_END;
        default: kind = KIND_INS_AT;
      endcase
      add_request(kind, $urandom, 8'(n / 2));
    end
    // Now full: a valid index reports full, an index past the length reports range.
    add_request(KIND_INS_END, 32'sd77, 8'd0);
    add_request(KIND_INS_AT, 32'sd78, 8'd17);
    add_request(KIND_DEL_AT, 32'sd0, 8'd16);
    add_request(KIND_DEL_AT, 32'sd0, 8'd15);
    add_request(KIND_DEL_FRONT, 32'sd0, 8'd0);
    add_request(KIND_DEL_END, 32'sd0, 8'd0);
    add_request(KIND_SPARE_LO, 32'sd11, 8'd3);
    add_request(KIND_SPARE_HI, -32'sd11, 8'd200);

    // Random part in segments that lean toward filling, draining or neither, so
    // that the sequence swings between empty and full.
    mode = 2;
    for (n = 0; n < RandomItems; n++) begin
      if (n % 30 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: ins_pct = 75;
        1: ins_pct = 25;
        default: ins_pct = 50;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 2) kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      else if ($urandom_range(0, 99) < ins_pct)
        kind = 3'($urandom_range(KIND_INS_FRONT, KIND_INS_AT));
      else kind = 3'($urandom_range(KIND_DEL_FRONT, KIND_DEL_AT));
      if ($urandom_range(0, 9) == 0) pos = 8'($urandom_range(0, 255));
      else pos = 8'($urandom_range(0, $urandom_range(1, CAPACITY + 1)));
      add_request(kind, $urandom, pos);
    end

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (queued_requests.size() != 0 || start_i || awaited_answers.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (awaited_answers.size() != 0) begin
      error_count += awaited_answers.size();
      $display("%0t ns: %0d results never arrived", $time, awaited_answers.size());
    end
    $display("Run covered %0d requests, %0d results checked, peak length %0d of %0d.",
             taken_count, checked, peak_len, CAPACITY);
    $display("Status counts: done %0d, empty %0d, range %0d, full %0d; %0d mismatches.",
             status_seen[ST_DONE], status_seen[ST_EMPTY], status_seen[ST_RANGE],
             status_seen[ST_FULL], error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
